FILE: hw/rtl/pid_pkg.sv
package pid_pkg;

  localparam int OUT_UPPER_DEF = 2047;
  localparam int OUT_LOWER_DEF = -2048;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DRIVE_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_TF      = 3'd3,
    REG_ELIM    = 3'd4,
    REG_SLIM    = 3'd5,
    REG_PCLAMP  = 3'd6,
    REG_ICLAMP  = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_IMUL,
    ST_NUM,
    ST_DEN,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_KP,
    MUL_KI,
    MUL_KD,
    MUL_TF
  } mul_sel_t;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] set_point;
    logic signed [15:0] process_value;
  } pid_in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      p_clamped;
    logic                      i_clamped;
    logic                      drive_clamped;
  } pid_out_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

FILE: hw/rtl/pid_div.sv
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module pid_div
  import pid_pkg::*;
#(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output div_ctl_t            ctl,
  output logic signed [W-1:0] quo
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q;
  logic [W-1:0]  dvs;
  logic [W:0]    rem;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          busy;
  logic          done;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  assign shifted = {rem[W-1:0], q[W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num[W-1] ? W'(-num) : num;
      dvs <= den[W-1] ? W'(-den) : den;
      rem <= '0;
      neg <= num[W-1] ^ den[W-1];
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial;
        q   <= {q[W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[W-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? W'(-q) : q;
  assign ctl = '{start: start, busy: busy, done: done};

endmodule

FILE: hw/rtl/pid_controller_antiwindup_core.sv
// Channel | Dir | Handshake        | Payload
// in      | in  | in_valid/ready   | pid_in_t
// out     | out | out_valid/ready  | pid_out_t
// cfg     | in  | cfg_we           | cfg_idx, cfg_data
// A sample passes from its transfer to out_valid through four 32x18
// multiplies on the shared multiplier, the bit-serial divider, then the sum
// and the output clamp. A zero divisor skips the divide.
// A clear gives no result.
// One item at a time; the result waits in the output register, and in_ready
// rises the cycle after it is transferred. Reset is synchronous.
module pid_controller_antiwindup_core
  import pid_pkg::*;
#(
  parameter int OUT_UPPER = OUT_UPPER_DEF,
  parameter int OUT_LOWER = OUT_LOWER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pid_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pid_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DW = 64;

  logic [31:0] kp_gain, ki_gain, kd_rate_gain, filter_ratio;
  logic [15:0] error_limit;
  logic [30:0] sum_limit, p_clamp_value, i_clamp_value;
  logic signed [16:0] last_error;
  logic signed [31:0] error_sum;

  state_t state, state_next;
  logic signed [16:0] e;
  logic signed [16:0] elim_s;
  logic signed [17:0] de;
  logic signed [DW-1:0] p_term, ki_e, num, den, d_term;
  logic pc;

  assign elim_s = signed'({1'b0, error_limit});

  // shared multiplier: 32-bit unsigned gain times signed operand
  mul_sel_t mul_sel;
  logic [31:0] mul_gain;
  logic signed [17:0] mul_op;
  logic [17:0] mul_mag;
  logic [49:0] mul_prod;
  logic signed [DW-1:0] mul_full, mul_trunc;

  always_comb begin
    case (mul_sel)
      MUL_KP:  begin mul_gain = kp_gain;      mul_op = 18'(e); end
      MUL_KI:  begin mul_gain = ki_gain;      mul_op = 18'(e); end
      MUL_KD:  begin mul_gain = kd_rate_gain; mul_op = de;     end
      MUL_TF:  begin mul_gain = filter_ratio; mul_op = de;     end
      default: begin mul_gain = kp_gain;      mul_op = 18'(e); end
    endcase
  end

  assign mul_mag   = mul_op[17] ? 18'(-mul_op) : mul_op;
  assign mul_prod  = 50'(mul_gain) * 50'(mul_mag);
  assign mul_full  = mul_op[17] ? -DW'(mul_prod) : DW'(mul_prod);
  assign mul_trunc = mul_op[17] ? -DW'(mul_prod >> FRAC_BITS)
                                : DW'(mul_prod >> FRAC_BITS);

  // divisor is the multiplier output plus 1 << FRAC_BITS, taken unregistered in ST_DEN
  assign den = mul_full + DW'(64'sd1 <<< FRAC_BITS);

  div_ctl_t div_ctl;
  logic signed [DW-1:0] div_q;
  logic div_start;

  pid_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(num), .den(den), .ctl(div_ctl), .quo(div_q)
  );

  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = in_data.operation ? ST_IDLE : ST_PMUL;
      ST_PMUL: state_next = ST_IMUL;
      ST_IMUL: state_next = ST_NUM;
      ST_NUM:  state_next = ST_DEN;
      ST_DEN:  state_next = (den != '0) ? ST_DIV : ST_SUM;
      ST_DIV:  if (div_ctl.done) state_next = ST_SUM;
      ST_SUM:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IMUL: mul_sel = MUL_KI;
      ST_NUM:  mul_sel = MUL_KD;
      ST_DEN:  mul_sel = MUL_TF;
      default: mul_sel = MUL_KP;
    endcase
    div_start = (state == ST_DEN) && (den != '0);
  end

  // integral path
  logic signed [DW-1:0] slim, sum_used, i_term, new_sum;
  logic ic;
  always_comb begin
    slim = DW'(sum_limit);
    if (DW'(error_sum) > slim) begin
      sum_used = slim; i_term = DW'(i_clamp_value); ic = 1'b1;
    end else if (DW'(error_sum) < -slim) begin
      sum_used = -slim; i_term = -DW'(i_clamp_value); ic = 1'b1;
    end else begin
      sum_used = DW'(error_sum); i_term = DW'(error_sum) + ki_e; ic = 1'b0;
    end
    new_sum = sum_used + ki_e;
    if (new_sum > DW'(64'sd2147483647)) new_sum = DW'(64'sd2147483647);
    if (new_sum < -DW'(64'sd2147483648)) new_sum = -DW'(64'sd2147483648);
  end

  logic signed [DW-1:0] total;
  logic ic_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      kp_gain       <= 32'h0001_0000;
      ki_gain       <= '0;
      kd_rate_gain  <= '0;
      filter_ratio  <= '0;
      error_limit   <= 16'hFFFF;
      sum_limit     <= 31'h7FFF_FFFF;
      p_clamp_value <= 31'd32767;
      i_clamp_value <= 31'd16383;
      last_error    <= '0;
      error_sum     <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_KP:     kp_gain <= cfg_data;
          REG_KI:     begin ki_gain <= cfg_data; error_sum <= '0; end
          REG_KD:     begin kd_rate_gain <= cfg_data; error_sum <= '0; end
          REG_TF:     begin filter_ratio <= cfg_data; error_sum <= '0; end
          REG_ELIM:   error_limit <= cfg_data[15:0];
          REG_SLIM:   sum_limit <= cfg_data[30:0];
          REG_PCLAMP: p_clamp_value <= cfg_data[30:0];
          REG_ICLAMP: i_clamp_value <= cfg_data[30:0];
          default:    ;
        endcase
      end
      if (state == ST_IDLE && in_valid && in_ready && in_data.operation) begin
        error_sum  <= '0;
        last_error <= '0;
      end
      if (state == ST_SUM) begin
        error_sum  <= new_sum[31:0];
        last_error <= e;
      end
      if (state == ST_OUT) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        e <= 17'(in_data.set_point) - 17'(in_data.process_value);
      end
      ST_PMUL: begin
        de <= 18'(e) - 18'(last_error);
        if (e > elim_s) begin
          p_term <= DW'(p_clamp_value); pc <= 1'b1;
        end else if (e < -elim_s) begin
          p_term <= -DW'(p_clamp_value); pc <= 1'b1;
        end else begin
          p_term <= mul_trunc; pc <= 1'b0;
        end
      end
      ST_IMUL: ki_e <= mul_trunc;
      ST_NUM:  num <= mul_full;
      ST_DEN:  d_term <= '0;
      ST_DIV:  if (div_ctl.done) d_term <= div_q;
      ST_SUM: begin
        total <= p_term + i_term + d_term;
        ic_r  <= ic;
      end
      ST_OUT: begin
        if (total > DW'(OUT_UPPER)) begin
          out_data.drive <= DRIVE_W'(OUT_UPPER); out_data.drive_clamped <= 1'b1;
        end else if (total < DW'(OUT_LOWER)) begin
          out_data.drive <= DRIVE_W'(OUT_LOWER); out_data.drive_clamped <= 1'b1;
        end else begin
          out_data.drive <= total[DRIVE_W-1:0]; out_data.drive_clamped <= 1'b0;
        end
        out_data.p_clamped <= pc;
        out_data.i_clamped <= ic_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/pid_checker.sv
module pid_checker
  import pid_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input pid_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input pid_out_t out_data
);

  // a clear transfer gives no result
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.operation |=> ##1 !out_valid)
    else $error("clear produced a result");

  // no input taken while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken with result pending");

  // a sample's result does not come too early after its transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.operation |=> ##4 !out_valid)
    else $error("result too early");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind pid_controller_antiwindup_core pid_checker u_pid_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
